FILE: hdl/pidq_pkg.sv
// Shared types, constants and saturation helper for the Q15 PID block.
package pidq_pkg;

    localparam logic signed [15:0] Q15_MAX = 16'sh7FFF;
    localparam logic signed [15:0] Q15_MIN = 16'sh8000;
    localparam logic [14:0]        Q15_ONE = 15'h7FFF;

    typedef enum logic [2:0] {
        REG_GAIN_P         = 3'd0,
        REG_GAIN_I         = 3'd1,
        REG_GAIN_D         = 3'd2,
        REG_ALPHA          = 3'd3,
        REG_BETA           = 3'd4,
        REG_DRIVE_MIN      = 3'd5,
        REG_DRIVE_MAX      = 3'd6,
        REG_INTEGRAL_LIMIT = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic signed [15:0] gain_p;
        logic signed [15:0] gain_i;
        logic signed [15:0] gain_d;
        logic [14:0]        deriv_filter_alpha;
        logic [14:0]        windup_beta;
        logic signed [15:0] drive_min;
        logic signed [15:0] drive_max;
        logic [14:0]        integral_limit;
    } cfg_t;

    // Saturate a wide signed value to the Q15 range.
    function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
        logic signed [15:0] r;
        if (v > 20'(Q15_MAX))
            r = Q15_MAX;
        else if (v < 20'(Q15_MIN))
            r = Q15_MIN;
        else
            r = v[15:0];
        return r;
    endfunction

endpackage

FILE: hdl/pidq_if.sv
// Valid/ready channel interfaces for the input and result beats.
interface pidq_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] setpoint;
    logic signed [15:0] measurement;

    modport source (output valid, output setpoint, output measurement, input ready);
    modport sink   (input valid, input setpoint, input measurement, output ready);
endinterface

interface pidq_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] drive;

    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);
endinterface

FILE: hdl/pidq_cfg.sv
// Configuration register bank for the Q15 PID block.
module pidq_cfg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    output pidq_pkg::cfg_t      cfg
);

    pidq_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p             <= 16'sd0;
            cfg_reg.gain_i             <= 16'sd0;
            cfg_reg.gain_d             <= 16'sd0;
            cfg_reg.deriv_filter_alpha <= 15'd0;
            cfg_reg.windup_beta        <= 15'd0;
            cfg_reg.drive_min          <= pidq_pkg::Q15_MIN;
            cfg_reg.drive_max          <= pidq_pkg::Q15_MAX;
            cfg_reg.integral_limit     <= pidq_pkg::Q15_ONE;
        end
        else if (cfg_we)
        begin
            unique case (pidq_pkg::reg_index_t'(cfg_index))
                pidq_pkg::REG_GAIN_P:         cfg_reg.gain_p             <= cfg_data;
                pidq_pkg::REG_GAIN_I:         cfg_reg.gain_i             <= cfg_data;
                pidq_pkg::REG_GAIN_D:         cfg_reg.gain_d             <= cfg_data;
                pidq_pkg::REG_ALPHA:          cfg_reg.deriv_filter_alpha <= cfg_data[14:0];
                pidq_pkg::REG_BETA:           cfg_reg.windup_beta        <= cfg_data[14:0];
                pidq_pkg::REG_DRIVE_MIN:      cfg_reg.drive_min          <= cfg_data;
                pidq_pkg::REG_DRIVE_MAX:      cfg_reg.drive_max          <= cfg_data;
                pidq_pkg::REG_INTEGRAL_LIMIT: cfg_reg.integral_limit     <= cfg_data[14:0];
                default:                      cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hdl/pidq_mul.sv
// Shared Q15 multiplier: floor((a*b) >> 15), saturated, registered.
module pidq_mul
(
    input  logic               clk,
    input  logic signed [15:0] a,
    input  logic signed [15:0] b,
    output logic signed [15:0] q
);

    logic signed [31:0] prod;
    logic signed [16:0] shr;
    logic signed [15:0] q_reg;

    always_comb
    begin
        prod = a * b;
        shr  = prod[31:15];   // arithmetic shift, rounds toward minus infinity
    end

    always_ff @(posedge clk)
    begin
        q_reg <= pidq_pkg::sat16(20'(shr));
    end

    assign q = q_reg;

endmodule

FILE: hdl/pid_q15_filtered_d_antiwindup.sv
// Top level: Q15 PID with filtered derivative and back-calculation anti-windup.
//
//  port       dir    beat contents
//  ---------  -----  -----------------------------------------------
//  in_ch      sink   setpoint, measurement (Q15 signed)
//  out_ch     source drive (Q15 signed, clamped to actuator limits)
//  cfg_*      in     write enable, 3-bit register index, 16-bit data
//
//  One beat in, one beat out. The result loads once the input beat has
//  passed every sequencer step; the next input beat is taken only after
//  the last result loads; six dependent products share one multiplier.
//  Reset clears the integral, filtered derivative and previous error and
//  loads register defaults. A result held by a stalled out_ch holds the
//  sequencer in its last step; input is taken again once the result loads.
module pid_q15_filtered_d_antiwindup
(
    input  logic        clk,
    input  logic        rst_n,
    pidq_in_if.sink     in_ch,
    pidq_out_if.source  out_ch,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // One-hot sequencer; each step issues at most one product, and the
    // product lands in mul_q in the step after it.
    typedef enum logic [11:0] {
        ST_IDLE = 12'b0000_0000_0001,
        ST_MP   = 12'b0000_0000_0010,  // gain_p * e; de = e - prev
        ST_MI   = 12'b0000_0000_0100,  // gain_i * e; take P
        ST_MA   = 12'b0000_0000_1000,  // alpha * fd; tentative integral
        ST_MB   = 12'b0000_0001_0000,  // (1 - alpha) * de
        ST_DF   = 12'b0000_0010_0000,  // filtered derivative
        ST_MD   = 12'b0000_0100_0000,  // gain_d * df
        ST_SUM  = 12'b0000_1000_0000,  // raw sum
        ST_CLMP = 12'b0001_0000_0000,  // overshoot
        ST_CORR = 12'b0010_0000_0000,  // beta * overshoot
        ST_INT  = 12'b0100_0000_0000,  // integral update
        ST_OUT  = 12'b1000_0000_0000   // output clamp and load
    } state_t;

    pidq_pkg::cfg_t cfg;

    state_t state_reg, state_next;

    // State carried between samples.
    logic signed [15:0] acc_reg, acc_next;
    logic signed [15:0] fd_reg, fd_next;
    logic signed [15:0] prev_reg, prev_next;

    // Per-sample scratch.
    logic signed [15:0] e_reg, e_next;
    logic signed [15:0] de_reg, de_next;
    logic signed [15:0] pt_reg, pt_next;
    logic signed [16:0] itent_reg, itent_next;
    logic signed [15:0] qa_reg, qa_next;
    logic signed [15:0] df_reg, df_next;
    logic signed [15:0] dt_reg, dt_next;
    logic signed [17:0] raw_reg, raw_next;
    logic signed [15:0] ov_reg, ov_next;

    logic               out_valid_reg, out_valid_next;
    logic signed [15:0] drive_reg, drive_next;

    logic signed [15:0] mul_a, mul_b, mul_q;

    logic signed [15:0] raw_clamped;
    logic signed [17:0] int_diff;
    logic signed [17:0] lim_pos, lim_neg;
    logic signed [17:0] int_clamped;
    logic signed [17:0] out_sum;
    logic               out_load;

    // Actuator clamp; upper bound first, so drive_min wins on inverted limits.
    function automatic logic signed [15:0] clamp_drive(
        input logic signed [19:0] v,
        input logic signed [15:0] lo,
        input logic signed [15:0] hi
    );
        logic signed [19:0] t;
        t = v;
        if (t > 20'(hi))
            t = 20'(hi);
        if (t < 20'(lo))
            t = 20'(lo);
        return t[15:0];
    endfunction

    pidq_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pidq_mul u_mul
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .q   (mul_q)
    );

    // Operand select for the shared multiplier.
    always_comb
    begin
        mul_a = 16'sd0;
        mul_b = 16'sd0;
        unique case (state_reg)
            ST_MP:
            begin
                mul_a = cfg.gain_p;
                mul_b = e_reg;
            end
            ST_MI:
            begin
                mul_a = cfg.gain_i;
                mul_b = e_reg;
            end
            ST_MA:
            begin
                mul_a = signed'({1'b0, cfg.deriv_filter_alpha});
                mul_b = fd_reg;
            end
            ST_MB:
            begin
                mul_a = signed'({1'b0, pidq_pkg::Q15_ONE - cfg.deriv_filter_alpha});
                mul_b = de_reg;
            end
            ST_MD:
            begin
                mul_a = cfg.gain_d;
                mul_b = df_reg;
            end
            ST_CORR:
            begin
                mul_a = signed'({1'b0, cfg.windup_beta});
                mul_b = ov_reg;
            end
            default:
            begin
                mul_a = 16'sd0;
                mul_b = 16'sd0;
            end
        endcase
    end

    // Combinational helpers for the clamp steps.
    always_comb
    begin
        raw_clamped = clamp_drive(20'(raw_reg), cfg.drive_min, cfg.drive_max);
        int_diff    = 18'(itent_reg) - 18'(mul_q);
        lim_pos     = signed'({3'b000, cfg.integral_limit});
        lim_neg     = -lim_pos;
        int_clamped = int_diff;
        if (int_clamped > lim_pos)
            int_clamped = lim_pos;
        if (int_clamped < lim_neg)
            int_clamped = lim_neg;
        out_sum     = 18'(pt_reg) + 18'(acc_reg) + 18'(dt_reg);
        out_load    = !out_valid_reg || out_ch.ready;
    end

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        fd_next        = fd_reg;
        prev_next      = prev_reg;
        e_next         = e_reg;
        de_next        = de_reg;
        pt_next        = pt_reg;
        itent_next     = itent_reg;
        qa_next        = qa_reg;
        df_next        = df_reg;
        dt_next        = dt_reg;
        raw_next       = raw_reg;
        ov_next        = ov_reg;
        drive_next     = drive_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    e_next     = pidq_pkg::sat16(20'(in_ch.setpoint) - 20'(in_ch.measurement));
                    state_next = ST_MP;
                end
            end
            ST_MP:
            begin
                de_next    = pidq_pkg::sat16(20'(e_reg) - 20'(prev_reg));
                state_next = ST_MI;
            end
            ST_MI:
            begin
                pt_next    = mul_q;
                state_next = ST_MA;
            end
            ST_MA:
            begin
                itent_next = 17'(acc_reg) + 17'(mul_q);
                state_next = ST_MB;
            end
            ST_MB:
            begin
                qa_next    = mul_q;
                state_next = ST_DF;
            end
            ST_DF:
            begin
                df_next    = pidq_pkg::sat16(20'(qa_reg) + 20'(mul_q));
                state_next = ST_MD;
            end
            ST_MD:
            begin
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                dt_next    = mul_q;
                raw_next   = 18'(pt_reg) + 18'(itent_reg) + 18'(mul_q);
                state_next = ST_CLMP;
            end
            ST_CLMP:
            begin
                ov_next    = pidq_pkg::sat16(20'(raw_reg) - 20'(raw_clamped));
                state_next = ST_CORR;
            end
            ST_CORR:
            begin
                state_next = ST_INT;
            end
            ST_INT:
            begin
                acc_next   = int_clamped[15:0];
                fd_next    = df_reg;
                prev_next  = e_reg;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    drive_next     = clamp_drive(20'(out_sum), cfg.drive_min, cfg.drive_max);
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            acc_reg       <= 16'sd0;
            fd_reg        <= 16'sd0;
            prev_reg      <= 16'sd0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            acc_reg       <= acc_next;
            fd_reg        <= fd_next;
            prev_reg      <= prev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg     <= e_next;
        de_reg    <= de_next;
        pt_reg    <= pt_next;
        itent_reg <= itent_next;
        qa_reg    <= qa_next;
        df_reg    <= df_next;
        dt_reg    <= dt_next;
        raw_reg   <= raw_next;
        ov_reg    <= ov_next;
        drive_reg <= drive_next;
    end

    assign in_ch.ready  = (state_reg == ST_IDLE);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.drive = drive_reg;

endmodule
